FILE: rtl/icfv_pkg.sv
// Package for the inverse-cube field vector pipeline.
// Word types, stage payload types, widths and register codes; no dependencies.
package icfv_pkg;

    localparam int DW  = 25;   // difference component
    localparam int QW  = 50;   // sum of squares
    localparam int LW  = 25;   // distance
    localparam int PW  = 56;   // strength times |d|
    localparam int NW  = 104;  // dividend
    localparam int DNW = 100;  // divisor
    localparam int QTW = 32;   // quotient bits
    localparam int CW  = 132;  // divider compare width

    localparam logic [31:0] STRENGTH_RST = 32'd65536;
    localparam logic [15:0] MIN_DIST_RST = 16'd66;

    localparam logic [0:0] CFG_STRENGTH = 1'b0;
    localparam logic [0:0] CFG_MIN_DIST = 1'b1;

    typedef struct packed {
        logic signed [23:0] observer_x;
        logic signed [23:0] observer_y;
        logic signed [23:0] observer_z;
        logic signed [23:0] magnet_x;
        logic signed [23:0] magnet_y;
        logic signed [23:0] magnet_z;
        logic               polarity;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic               saturated;
    } t_out_word;

    typedef struct packed {
        logic [2:0]         neg;
        logic               zero;
        logic [2:0][PW-1:0] num;
    } t_side;

    typedef struct packed {
        logic [QW-1:0] rem;
        logic [QW:0]   root;
        t_side         side;
    } t_sq_word;

    typedef struct packed {
        logic [2:0][NW-1:0]  rem;
        logic [2:0][QTW-1:0] quo;
        logic [2:0]          ovf;
        logic [2:0]          neg;
        logic                zero;
        logic [DNW-1:0]      den;
    } t_dv_word;

endpackage

FILE: rtl/icfv_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on icfv_pkg.
interface icfv_in_if;
    import icfv_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface icfv_out_if;
    import icfv_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/icfv_front.sv
// Front stages: difference vector, squares, sum of squares and numerators.
// Three register stages; depends on icfv_pkg.
module icfv_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  icfv_pkg::t_in_word i_data,
    input  logic [31:0]      i_strength,
    output logic             o_valid,
    output icfv_pkg::t_sq_word o_data
);
    import icfv_pkg::*;

    logic                  r_v1, r_v2, r_v3;
    logic signed [DW-1:0]  r_d1 [3];
    logic signed [DW-1:0]  n_d1 [3];
    logic                  r_s1;
    logic [DW-1:0]         r_abs2 [3];
    logic [DW-1:0]         n_abs2 [3];
    logic [QW-2:0]         r_sq2 [3];
    logic [QW-2:0]         n_sq2 [3];
    logic [2:0]            r_neg2, n_neg2;
    t_sq_word              r_out, n_out;
    logic signed [QW-1:0]  w_prod [3];
    logic [PW:0]           w_p [3];

    always_comb begin
        n_d1[0] = {i_data.observer_x[23], i_data.observer_x}
                - {i_data.magnet_x[23], i_data.magnet_x};
        n_d1[1] = {i_data.observer_y[23], i_data.observer_y}
                - {i_data.magnet_y[23], i_data.magnet_y};
        n_d1[2] = {i_data.observer_z[23], i_data.observer_z}
                - {i_data.magnet_z[23], i_data.magnet_z};
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_prod[i] = r_d1[i] * r_d1[i];
            n_sq2[i]  = w_prod[i][QW-2:0];
            n_abs2[i] = r_d1[i][DW-1] ? DW'(-r_d1[i]) : DW'(r_d1[i]);
            n_neg2[i] = r_d1[i][DW-1] ^ r_s1;
        end
    end

    always_comb begin
        n_out.rem       = QW'(r_sq2[0]) + QW'(r_sq2[1]) + QW'(r_sq2[2]);
        n_out.root      = '0;
        n_out.side.neg  = r_neg2;
        n_out.side.zero = (r_abs2[0] == '0) && (r_abs2[1] == '0) && (r_abs2[2] == '0);
        for (int i = 0; i < 3; i++) begin
            w_p[i]              = i_strength * r_abs2[i];
            n_out.side.num[i]   = w_p[i][PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1   <= n_d1;
            r_s1   <= i_data.polarity;
            r_abs2 <= n_abs2;
            r_sq2  <= n_sq2;
            r_neg2 <= n_neg2;
            r_out  <= n_out;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_out;
endmodule

FILE: rtl/icfv_sqrt_step.sv
// One digit step of the integer square root, one register stage.
// Depends on icfv_pkg.
module icfv_sqrt_step #(
    parameter int unsigned STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  icfv_pkg::t_sq_word i_data,
    output logic               o_valid,
    output icfv_pkg::t_sq_word o_data
);
    import icfv_pkg::*;

    localparam logic [QW:0] BIT_W = (QW + 1)'(1) << (2 * (LW - 1 - STEP));

    logic        r_v;
    t_sq_word    r_data, n_data;
    logic [QW:0] w_sum;

    always_comb begin
        n_data = i_data;
        w_sum  = i_data.root + BIT_W;
        if ({1'b0, i_data.rem} >= w_sum) begin
            n_data.rem  = i_data.rem - w_sum[QW-1:0];
            n_data.root = (i_data.root >> 1) + BIT_W;
        end else begin
            n_data.root = i_data.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;
endmodule

FILE: rtl/icfv_denom.sv
// Divisor stages: distance clamp, L * Lc^3 in partial products, overflow check.
// Five register stages; depends on icfv_pkg.
module icfv_denom (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  icfv_pkg::t_sq_word i_data,
    input  logic [15:0]        i_min_dist,
    output logic               o_valid,
    output icfv_pkg::t_dv_word o_data
);
    import icfv_pkg::*;

    logic [4:0]        r_v;
    t_side             r_side [4];
    logic [LW-1:0]     r_l, r_lc, w_l, w_md;
    logic [2*LW-1:0]   r_a, r_b;
    logic [2*LW-1:0]   r_p11, r_p10, r_p01, r_p00;
    logic [DNW-1:0]    r_den, n_den;
    t_dv_word          r_out, n_out;

    assign w_l  = i_data.root[LW-1:0];
    assign w_md = LW'(i_min_dist);

    always_comb begin
        n_den = {r_p11, {(2*LW){1'b0}}}
              + {{LW{1'b0}}, r_p10, {LW{1'b0}}}
              + {{LW{1'b0}}, r_p01, {LW{1'b0}}}
              + {{(2*LW){1'b0}}, r_p00};
    end

    always_comb begin
        n_out.den  = r_den;
        n_out.neg  = r_side[3].neg;
        n_out.zero = r_side[3].zero;
        n_out.quo  = '0;
        for (int i = 0; i < 3; i++) begin
            n_out.rem[i] = {r_side[3].num[i], 48'd0};
            n_out.ovf[i] = {28'd0, r_side[3].num[i], 48'd0} >= {r_den, 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_data.side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
            r_l       <= w_l;
            r_lc      <= (w_l < w_md) ? w_md : w_l;
            r_a       <= r_l * r_lc;
            r_b       <= r_lc * r_lc;
            r_p11     <= r_a[2*LW-1:LW] * r_b[2*LW-1:LW];
            r_p10     <= r_a[2*LW-1:LW] * r_b[LW-1:0];
            r_p01     <= r_a[LW-1:0] * r_b[2*LW-1:LW];
            r_p00     <= r_a[LW-1:0] * r_b[LW-1:0];
            r_den     <= n_den;
            r_out     <= n_out;
        end
    end

    assign o_valid = r_v[4];
    assign o_data  = r_out;
endmodule

FILE: rtl/icfv_div_step.sv
// One restoring division step for all three components, one register stage.
// Depends on icfv_pkg.
module icfv_div_step #(
    parameter int unsigned BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  icfv_pkg::t_dv_word i_data,
    output logic               o_valid,
    output icfv_pkg::t_dv_word o_data
);
    import icfv_pkg::*;

    logic        r_v;
    t_dv_word    r_data, n_data;
    logic [CW-1:0] w_t;

    assign w_t = {32'd0, i_data.den} << BIT;

    always_comb begin
        n_data = i_data;
        for (int i = 0; i < 3; i++) begin
            if ({28'd0, i_data.rem[i]} >= w_t) begin
                n_data.rem[i]      = i_data.rem[i] - w_t[NW-1:0];
                n_data.quo[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;
endmodule

FILE: rtl/icfv_out.sv
// Sign, saturation and the output register with its skid stage.
// Depends on icfv_pkg and icfv_if.
module icfv_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  icfv_pkg::t_dv_word i_data,
    output logic               o_skid_full,
    icfv_out_if.source         o_out
);
    import icfv_pkg::*;

    logic            r_out_v, r_skid_v;
    t_out_word       r_out, r_skid, n_word;
    logic [2:0][31:0] w_f;
    logic [2:0]      w_sat;
    logic            w_take, w_wr;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_f[i]   = '0;
            w_sat[i] = 1'b0;
            if (!i_data.zero) begin
                if (i_data.neg[i]) begin
                    if (i_data.ovf[i] || (i_data.quo[i][31] && (i_data.quo[i][30:0] != '0))) begin
                        w_f[i]   = 32'h8000_0000;
                        w_sat[i] = 1'b1;
                    end else begin
                        w_f[i] = 32'd0 - i_data.quo[i];
                    end
                end else begin
                    if (i_data.ovf[i] || i_data.quo[i][31]) begin
                        w_f[i]   = 32'h7FFF_FFFF;
                        w_sat[i] = 1'b1;
                    end else begin
                        w_f[i] = i_data.quo[i];
                    end
                end
            end
        end
        n_word.field_x   = w_f[0];
        n_word.field_y   = w_f[1];
        n_word.field_z   = w_f[2];
        n_word.saturated = |w_sat;
    end

    assign w_take = r_out_v && o_out.ready;
    assign w_wr   = i_valid && !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_wr;
            end
        end else if (w_wr) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_take) begin
            r_out <= r_skid_v ? r_skid : n_word;
        end
        if (r_out_v && !w_take && w_wr) begin
            r_skid <= n_word;
        end
    end

    assign o_skid_full = r_skid_v;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;
endmodule

FILE: rtl/inverse_cube_field_vector.sv
// Inverse-cube field vector of a point magnet, fixed point, fully pipelined.
// Takes one word per cycle while no stall is held.
// The depth is set by the square root (one digit per stage, 25 stages) and the
// divider (one quotient bit per stage, 32 stages). Stalls hold every stage.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
module inverse_cube_field_vector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    icfv_in_if.sink     i_in,
    icfv_out_if.source  o_out
);
    import icfv_pkg::*;

    logic        r_strength_v;
    logic [31:0] r_strength;
    logic [15:0] r_min_dist;
    logic        w_en, w_skid_full;

    logic        w_sq_v [LW+1];
    t_sq_word    w_sq_d [LW+1];
    logic        w_dv_v [QTW+1];
    t_dv_word    w_dv_d [QTW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength_v <= 1'b1;
            r_strength   <= STRENGTH_RST;
            r_min_dist   <= MIN_DIST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STRENGTH: r_strength <= i_cfg_data;
                CFG_MIN_DIST: r_min_dist <= i_cfg_data[15:0];
                default: r_strength_v <= 1'b1;
            endcase
        end
    end

    assign w_en       = !w_skid_full && r_strength_v;
    assign i_in.ready = w_en;

    icfv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in.valid),
        .i_data     (i_in.data),
        .i_strength (r_strength),
        .o_valid    (w_sq_v[0]),
        .o_data     (w_sq_d[0])
    );

    for (genvar s = 0; s < LW; s++) begin : g_sqrt
        icfv_sqrt_step #(.STEP(s)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[s]),
            .i_data  (w_sq_d[s]),
            .o_valid (w_sq_v[s+1]),
            .o_data  (w_sq_d[s+1])
        );
    end

    icfv_denom u_denom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_sq_v[LW]),
        .i_data     (w_sq_d[LW]),
        .i_min_dist (r_min_dist),
        .o_valid    (w_dv_v[0]),
        .o_data     (w_dv_d[0])
    );

    for (genvar k = 0; k < QTW; k++) begin : g_div
        icfv_div_step #(.BIT(QTW - 1 - k)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[k]),
            .i_data  (w_dv_d[k]),
            .o_valid (w_dv_v[k+1]),
            .o_data  (w_dv_d[k+1])
        );
    end

    icfv_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_dv_v[QTW] && w_en),
        .i_data      (w_dv_d[QTW]),
        .o_skid_full (w_skid_full),
        .o_out       (o_out)
    );
endmodule

FILE: bench/tb_inverse_cube_field_vector.sv
// Self-checking bench for inverse_cube_field_vector: drives observer/magnet words,
// predicts each field vector in fixed point and compares it with the result words.
// Depends on icfv_pkg, icfv_in_if, icfv_out_if and the block itself.
module tb_inverse_cube_field_vector;
    timeunit 1ns;
    timeprecision 1ps;
    import icfv_pkg::*;

    localparam int PIPE_DEPTH = 66;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    icfv_in_if  in_ch ();
    icfv_out_if out_ch ();

    inverse_cube_field_vector i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    logic [31:0] strength;
    logic [15:0] min_dist;
    t_out_word   pending_fields[$];
    int          n_errors;
    int          n_sent;
    int          n_checked;
    int          n_sat;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic t_out_word field_of(t_in_word w);
        logic signed [24:0] diff[3];
        logic [63:0]        sq;
        logic [63:0]        x;
        logic [63:0]        r;
        logic [63:0]        b;
        logic [63:0]        len;
        logic [63:0]        lc;
        logic [63:0]        mag;
        logic [63:0]        prod;
        logic [127:0]       den;
        logic [127:0]       quo;
        logic [31:0]        comp[3];
        logic               neg;
        logic               sat;
        t_out_word          res;
        diff[0] = w.observer_x - w.magnet_x;
        diff[1] = w.observer_y - w.magnet_y;
        diff[2] = w.observer_z - w.magnet_z;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            sq += 64'(longint'(diff[i]) * longint'(diff[i]));
        end
        res = '0;
        if (sq == 0) begin
            return res;
        end
        x = sq;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        len = r;
        lc  = (len < 64'(min_dist)) ? 64'(min_dist) : len;
        den = 128'(len) * 128'(lc) * 128'(lc) * 128'(lc);
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            mag  = diff[i] < 0 ? 64'(-longint'(diff[i])) : 64'(diff[i]);
            prod = 64'(strength) * mag;
            neg  = (diff[i] < 0) ^ w.polarity;
            quo  = (128'(prod) << 48) / den;
            if (neg) begin
                if (quo > 128'h8000_0000) begin
                    quo = 128'h8000_0000;
                    sat = 1'b1;
                end
                comp[i] = 32'(-quo);
            end else begin
                if (quo > 128'h7FFF_FFFF) begin
                    quo = 128'h7FFF_FFFF;
                    sat = 1'b1;
                end
                comp[i] = quo[31:0];
            end
        end
        res.field_x   = comp[0];
        res.field_y   = comp[1];
        res.field_z   = comp[2];
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch on result %0d: %s got %h want %h", n_checked, what, got, want);
    endtask

    // result side: check accepted words, then pick next ready
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_fields.size() == 0) begin
                n_errors++;
                $display("unexpected result word %h", out_ch.data);
            end else begin
                want = pending_fields.pop_front();
                if (out_ch.data.field_x !== want.field_x)
                    report_mismatch("field_x", out_ch.data.field_x, want.field_x);
                if (out_ch.data.field_y !== want.field_y)
                    report_mismatch("field_y", out_ch.data.field_y, want.field_y);
                if (out_ch.data.field_z !== want.field_z)
                    report_mismatch("field_z", out_ch.data.field_z, want.field_z);
                if (out_ch.data.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(out_ch.data.saturated),
                                    32'(want.saturated));
                n_sat += int'(want.saturated);
            end
            n_checked++;
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_fields.insert(pending_fields.size(), field_of(w));
        n_sent++;
    endtask

    task automatic finish_sending();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        finish_sending();
        while (pending_fields.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_STRENGTH) strength = value;
        else min_dist = value[15:0];
    endtask

    function automatic t_in_word make_word(logic signed [23:0] ox, logic signed [23:0] oy,
                                           logic signed [23:0] oz, logic signed [23:0] mx,
                                           logic signed [23:0] my, logic signed [23:0] mz,
                                           logic pol);
        t_in_word w;
        w.observer_x = ox; w.observer_y = oy; w.observer_z = oz;
        w.magnet_x = mx; w.magnet_y = my; w.magnet_z = mz;
        w.polarity = pol;
        return w;
    endfunction

    function automatic logic signed [23:0] near(logic signed [23:0] base);
        int unsigned span;
        span = 1 << $urandom_range(0, 22);
        return base + 24'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        w = t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(3) != 0) begin
            w.magnet_x = near(w.observer_x);
            w.magnet_y = near(w.observer_y);
            w.magnet_z = near(w.observer_z);
        end
        if ($urandom_range(30) == 0) begin
            w.magnet_x = w.observer_x;
            w.magnet_y = w.observer_y;
            w.magnet_z = w.observer_z;
        end
        return w;
    endfunction

    task automatic test_directed();
        logic signed [23:0] hi;
        logic signed [23:0] lo;
        logic               pol;
        hi = 24'sh7FFFFF;
        lo = -24'sh800000;
        for (int p = 0; p < 2; p++) begin
            pol = 1'(p);
            send_word(make_word(0, 0, 0, 0, 0, 0, pol));
            send_word(make_word(hi, hi, hi, lo, lo, lo, pol));
            send_word(make_word(lo, lo, lo, hi, hi, hi, pol));
            send_word(make_word(hi, 0, 0, lo, 0, 0, pol));
            send_word(make_word(1, 0, 0, 0, 0, 0, pol));
            send_word(make_word(0, -1, 0, 0, 0, 0, pol));
            send_word(make_word(0, 0, 24'sh10000, 0, 0, 0, pol));
            send_word(make_word(24'sh10000, -24'sh10000, 24'sh8000, 0, 0, 0, pol));
            send_word(make_word(40, 30, 0, 0, 0, 0, pol));
            send_word(make_word(hi, lo, 5, hi, lo, 5, pol));
            send_word(make_word(-24'sh20000, 24'sh30000, -24'sh40000,
                                24'sh1, 24'sh2, 24'sh3, pol));
        end
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) send_word(random_word());
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int k = 0; k < 150; k++) send_word(random_word());
    endtask

    task automatic test_register_corners();
        write_reg(CFG_STRENGTH, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_DIST, 32'h0000_FFFF);
        test_directed();
        test_random(60);
        write_reg(CFG_STRENGTH, 32'd0);
        write_reg(CFG_MIN_DIST, 32'd1);
        test_directed();
        test_random(40);
        write_reg(CFG_STRENGTH, 32'd1);
        test_random(40);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_STRENGTH;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        strength     = STRENGTH_RST;
        min_dist     = MIN_DIST_RST;
        n_errors     = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_sat        = 0;
        hold_cycles  = 0;
        send_idle_pct = 18;
        recv_idle_pct = 65;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300);
        send_idle_pct = 65;
        recv_idle_pct = 18;
        write_reg(CFG_STRENGTH, $urandom);
        write_reg(CFG_MIN_DIST, $urandom_range(1, 65535));
        test_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_register_corners();
        write_reg(CFG_STRENGTH, $urandom_range(1 << 12, 1 << 20));
        write_reg(CFG_MIN_DIST, $urandom_range(1, 4096));
        test_random(200);
        drain();

        $display("sent %0d words, checked %0d results, %0d saturated", n_sent, n_checked,
                 n_sat);
        $display("covered reset and corner register values, both polarities, stalls");
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

FILE: inverse_cube_field_vector.f
rtl/icfv_pkg.sv
rtl/icfv_if.sv
rtl/icfv_front.sv
rtl/icfv_sqrt_step.sv
rtl/icfv_denom.sv
rtl/icfv_div_step.sv
rtl/icfv_out.sv
rtl/inverse_cube_field_vector.sv
bench/tb_inverse_cube_field_vector.sv
